/* rtl/core/afd_pkg.sv */
// Shared types and constants for the addressed frame deframer.
package afd_pkg;

  // Frame delimiters and header tags.
  localparam logic [7:0] SofByte   = 8'haa;
  localparam logic [7:0] EofByte   = 8'hab;
  localparam logic [7:0] TargetTag = 8'hd0;
  localparam logic [7:0] SourceTag = 8'he0;
  localparam logic [7:0] TagMask   = 8'hf0;

  // Source nibbles that switch checksum mode.
  localparam logic [3:0] SrcCheckOn  = 4'ha;
  localparam logic [3:0] SrcCheckOff = 4'h9;

  // Payload sizing: up to MaxLength bytes per frame.
  localparam int unsigned MaxLength = 16;
  localparam int unsigned IdxW      = $clog2(MaxLength);
  localparam int unsigned LenW      = $clog2(MaxLength + 1);

  // Two payload banks so one frame can be emitted while the next is received.
  localparam int unsigned NumBanks   = 2;
  localparam int unsigned BankW      = $clog2(NumBanks);
  localparam int unsigned AddrW      = BankW + IdxW;
  localparam int unsigned StoreDepth = NumBanks * MaxLength;

  // Frame event queue depth.
  localparam int unsigned EvqDepth = 4;
  localparam int unsigned EvqPtrW  = $clog2(EvqDepth);
  localparam int unsigned EvqCntW  = $clog2(EvqDepth + 1);

  // Parser phases.
  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhTarget  = 3'd1,
    PhSource  = 3'd2,
    PhId      = 3'd3,
    PhLen     = 3'd4,
    PhPayload = 3'd5,
    PhCheck   = 3'd6,
    PhEnd     = 3'd7
  } phase_e;

  // One finished frame (or checksum error) handed to the emitter.
  typedef struct packed {
    logic             status;
    logic [3:0]       dest_id;
    logic [3:0]       src_id;
    logic [7:0]       packet_id;
    logic             checked_mode;
    logic [LenW-1:0]  plen;
    logic [BankW-1:0] bank;
  } frame_evt_t;

  // Payload store write port.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  // Emitter status seen by the parser.
  typedef struct packed {
    logic                evq_full;
    logic [NumBanks-1:0] bank_busy;
  } emit_status_t;

  // One result beat.
  typedef struct packed {
    logic            status;
    logic [3:0]      dest_id;
    logic [3:0]      src_id;
    logic [7:0]      packet_id;
    logic            checked_mode;
    logic [IdxW-1:0] payload_index;
    logic [7:0]      payload_byte;
    logic            payload_valid;
    logic            last;
  } result_t;

endpackage

/* rtl/core/afd_parser.sv */
// Frame parser: header checks, running checksum and payload store writes.
module afd_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,
  input  afd_pkg::emit_status_t emit_status_i,
  output logic                  evt_push_o,
  output afd_pkg::frame_evt_t   evt_o,
  output afd_pkg::store_wr_t    store_wr_o
);

  afd_pkg::phase_e                  phase_q, phase_d;
  logic                             no_cks_q, no_cks_d;
  logic [3:0]                       dest_q, dest_d;
  logic [3:0]                       src_q, src_d;
  logic [7:0]                       pid_q, pid_d;
  logic [afd_pkg::LenW-1:0]         len_q, len_d;
  logic [afd_pkg::LenW-1:0]         count_q, count_d;
  logic [7:0]                       sum_q, sum_d;
  logic [afd_pkg::BankW-1:0]        wbank_q, wbank_d;
  logic                             accept;
  logic                             checked;
  logic [afd_pkg::LenW-1:0]         plen;
  logic [afd_pkg::LenW-1:0]         plen_new;
  logic [afd_pkg::LenW-1:0]         count_inc;
  logic                             len_bad;
  logic                             eof_ok;

  // Stall when the event queue cannot take a frame, or when the bank about to
  // receive payload is still being emitted.
  assign in_stall_o = emit_status_i.evq_full ||
                      ((phase_q == afd_pkg::PhPayload) &&
                       emit_status_i.bank_busy[wbank_q]);
  assign accept     = in_valid_i && !in_stall_o;

  // Payload length of the current frame, and of a length byte being received.
  assign checked   = !no_cks_q;
  assign plen      = len_q - afd_pkg::LenW'(checked);
  assign plen_new  = rx_byte_i[afd_pkg::LenW-1:0] - afd_pkg::LenW'(checked);
  assign count_inc = count_q + afd_pkg::LenW'(1);
  assign len_bad   = (rx_byte_i > 8'(afd_pkg::MaxLength)) ||
                     (checked && (rx_byte_i == 8'd0));
  assign eof_ok    = (rx_byte_i == afd_pkg::EofByte);

  // Next state and frame context.
  always_comb begin
    phase_d  = phase_q;
    no_cks_d = no_cks_q;
    dest_d   = dest_q;
    src_d    = src_q;
    pid_d    = pid_q;
    len_d    = len_q;
    count_d  = count_q;
    sum_d    = sum_q;
    wbank_d  = wbank_q;
    if (accept) begin
      unique case (phase_q)
        afd_pkg::PhHunt: begin
          if (rx_byte_i == afd_pkg::SofByte) begin
            sum_d   = rx_byte_i;
            phase_d = afd_pkg::PhTarget;
          end
        end
        afd_pkg::PhTarget: begin
          if ((rx_byte_i & afd_pkg::TagMask) == afd_pkg::TargetTag) begin
            dest_d  = rx_byte_i[3:0];
            sum_d   = sum_q + rx_byte_i;
            phase_d = afd_pkg::PhSource;
          end else begin
            phase_d = afd_pkg::PhHunt;
          end
        end
        afd_pkg::PhSource: begin
          if ((rx_byte_i & afd_pkg::TagMask) == afd_pkg::SourceTag) begin
            src_d = rx_byte_i[3:0];
            if (rx_byte_i[3:0] == afd_pkg::SrcCheckOn) begin
              no_cks_d = 1'b0;
            end else if (rx_byte_i[3:0] == afd_pkg::SrcCheckOff) begin
              no_cks_d = 1'b1;
            end
            sum_d   = sum_q + rx_byte_i;
            phase_d = afd_pkg::PhId;
          end else begin
            phase_d = afd_pkg::PhHunt;
          end
        end
        afd_pkg::PhId: begin
          pid_d   = rx_byte_i;
          sum_d   = sum_q + rx_byte_i;
          phase_d = afd_pkg::PhLen;
        end
        afd_pkg::PhLen: begin
          if (len_bad) begin
            phase_d = afd_pkg::PhHunt;
          end else begin
            len_d   = rx_byte_i[afd_pkg::LenW-1:0];
            sum_d   = sum_q + rx_byte_i;
            count_d = '0;
            if (plen_new != '0) begin
              phase_d = afd_pkg::PhPayload;
            end else if (checked) begin
              phase_d = afd_pkg::PhCheck;
            end else begin
              phase_d = afd_pkg::PhEnd;
            end
          end
        end
        afd_pkg::PhPayload: begin
          sum_d   = sum_q + rx_byte_i;
          count_d = count_inc;
          if (count_inc >= plen) begin
            phase_d = checked ? afd_pkg::PhCheck : afd_pkg::PhEnd;
          end
        end
        afd_pkg::PhCheck: begin
          phase_d = (rx_byte_i != sum_q) ? afd_pkg::PhHunt : afd_pkg::PhEnd;
        end
        afd_pkg::PhEnd: begin
          // A good frame with payload hands its bank to the emitter.
          if (eof_ok && (plen != '0)) begin
            wbank_d = wbank_q + afd_pkg::BankW'(1);
          end
          phase_d = afd_pkg::PhHunt;
        end
        default: begin
          phase_d = afd_pkg::PhHunt;
        end
      endcase
    end
  end

  // Event push and payload store write.
  always_comb begin
    evt_o.status       = 1'b0;
    evt_o.dest_id      = dest_q;
    evt_o.src_id       = src_q;
    evt_o.packet_id    = pid_q;
    evt_o.checked_mode = checked;
    evt_o.plen         = plen;
    evt_o.bank         = wbank_q;
    evt_push_o         = 1'b0;
    store_wr_o.en      = 1'b0;
    store_wr_o.addr    = {wbank_q, count_q[afd_pkg::IdxW-1:0]};
    store_wr_o.data    = rx_byte_i;
    if (accept) begin
      unique case (phase_q)
        afd_pkg::PhPayload: begin
          store_wr_o.en = 1'b1;
        end
        afd_pkg::PhCheck: begin
          if (rx_byte_i != sum_q) begin
            evt_push_o   = 1'b1;
            evt_o.status = 1'b1;
            evt_o.plen   = '0;
          end
        end
        afd_pkg::PhEnd: begin
          evt_push_o = eof_ok;
        end
        default: begin
          evt_push_o = 1'b0;
        end
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= afd_pkg::PhHunt;
      no_cks_q <= 1'b0;
      dest_q   <= '0;
      src_q    <= '0;
      pid_q    <= '0;
      len_q    <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      wbank_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      no_cks_q <= no_cks_d;
      dest_q   <= dest_d;
      src_q    <= src_d;
      pid_q    <= pid_d;
      len_q    <= len_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      wbank_q  <= wbank_d;
    end
  end

endmodule

/* rtl/core/afd_emitter.sv */
// Frame emitter: event queue, banked payload store and the result pipeline.
module afd_emitter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  evt_push_i,
  input  afd_pkg::frame_evt_t   evt_i,
  input  afd_pkg::store_wr_t    store_wr_i,
  output afd_pkg::emit_status_t emit_status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output afd_pkg::result_t      result_o
);

  afd_pkg::frame_evt_t             evq_q [afd_pkg::EvqDepth];
  logic [afd_pkg::EvqPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [afd_pkg::EvqCntW-1:0]     cnt_q, cnt_d;
  logic [afd_pkg::NumBanks-1:0]    busy_q, busy_d;
  logic [7:0]                      store_q [afd_pkg::StoreDepth];
  logic [7:0]                      rd_data_q;
  logic [afd_pkg::IdxW-1:0]        idx_q;
  logic                            s1_valid_q;
  afd_pkg::result_t                s1_q, s1_d;
  logic                            out_valid_q;
  afd_pkg::result_t                out_q, out_d;
  afd_pkg::frame_evt_t             head;
  logic                            evq_empty;
  logic                            out_free;
  logic                            s1_move;
  logic                            issue;
  logic                            head_last;
  logic                            head_has_data;

  assign head          = evq_q[rd_ptr_q];
  assign evq_empty     = (cnt_q == '0);
  assign head_has_data = (head.plen != '0);
  assign head_last     = !head_has_data ||
                         ({1'b0, idx_q} + afd_pkg::LenW'(1) == head.plen);

  // Pipeline advance: the output register, then the read stage behind it.
  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_move  = s1_valid_q && out_free;
  assign issue    = !evq_empty && (!s1_valid_q || s1_move);

  assign emit_status_o.evq_full  = (cnt_q == afd_pkg::EvqCntW'(afd_pkg::EvqDepth));
  assign emit_status_o.bank_busy = busy_q;

  // Result fields for the beat being issued; the byte joins from the store.
  always_comb begin
    s1_d.status        = head.status;
    s1_d.dest_id       = head.dest_id;
    s1_d.src_id        = head.src_id;
    s1_d.packet_id     = head.packet_id;
    s1_d.checked_mode  = head.checked_mode;
    s1_d.payload_index = head_has_data ? idx_q : '0;
    s1_d.payload_byte  = '0;
    s1_d.payload_valid = head_has_data;
    s1_d.last          = head_last;
  end

  // Output beat: read stage fields with the byte read from the store.
  always_comb begin
    out_d              = s1_q;
    out_d.payload_byte = s1_q.payload_valid ? rd_data_q : 8'd0;
  end

  // Queue fill and bank ownership.
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (evt_push_i && !(issue && head_last)) begin
      cnt_d = cnt_q + afd_pkg::EvqCntW'(1);
    end else if (!evt_push_i && issue && head_last) begin
      cnt_d = cnt_q - afd_pkg::EvqCntW'(1);
    end
    if (issue && head_last && head_has_data) begin
      busy_d[head.bank] = 1'b0;
    end
    if (evt_push_i && (evt_i.plen != '0)) begin
      busy_d[evt_i.bank] = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      busy_q      <= '0;
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      if (evt_push_i) begin
        wr_ptr_q <= wr_ptr_q + afd_pkg::EvqPtrW'(1);
      end
      if (issue) begin
        if (head_last) begin
          rd_ptr_q <= rd_ptr_q + afd_pkg::EvqPtrW'(1);
          idx_q    <= '0;
        end else begin
          idx_q <= idx_q + afd_pkg::IdxW'(1);
        end
      end
      s1_valid_q  <= issue || (s1_valid_q && !s1_move);
      out_valid_q <= s1_move || (out_valid_q && out_stall_i);
    end
  end

  // Event queue entries.
  always_ff @(posedge clk_i) begin
    if (evt_push_i) begin
      evq_q[wr_ptr_q] <= evt_i;
    end
  end

  // Payload store: one write port from the parser, one registered read port.
  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      store_q[store_wr_i.addr] <= store_wr_i.data;
    end
    if (issue) begin
      rd_data_q <= store_q[{head.bank, idx_q}];
    end
  end

  // Read stage and output register payload.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

/* rtl/core/addressed_frame_deframer_core.sv */
// Top level of the addressed frame deframer.
// Takes one received byte per beat and, at a good end byte (or at a mismatching
// checksum byte), gives the frame's payload as one result beat per byte (a
// single beat for an empty payload or a checksum mismatch), last marked on the
// final beat. Input bytes are taken one per cycle; the input stalls only when
// the four-entry frame queue is full or when a frame's payload would land in a
// store bank whose earlier frame is still being emitted. Results leave at one
// per cycle while out_stall_i is low, behind a two-stage pipeline (store read,
// output register).
module addressed_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       status_o,
  output logic [3:0] dest_id_o,
  output logic [3:0] src_id_o,
  output logic [7:0] packet_id_o,
  output logic       checked_mode_o,
  output logic [3:0] payload_index_o,
  output logic [7:0] payload_byte_o,
  output logic       payload_valid_o,
  output logic       last_o
);

  afd_pkg::emit_status_t emit_status;
  afd_pkg::frame_evt_t   evt;
  afd_pkg::store_wr_t    store_wr;
  afd_pkg::result_t      result;
  logic                  evt_push;

  // Header and checksum parsing.
  afd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .emit_status_i (emit_status),
    .evt_push_o    (evt_push),
    .evt_o         (evt),
    .store_wr_o    (store_wr)
  );

  // Result emission.
  afd_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_push_i    (evt_push),
    .evt_i         (evt),
    .store_wr_i    (store_wr),
    .emit_status_o (emit_status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_o      (result)
  );

  assign status_o        = result.status;
  assign dest_id_o       = result.dest_id;
  assign src_id_o        = result.src_id;
  assign packet_id_o     = result.packet_id;
  assign checked_mode_o  = result.checked_mode;
  assign payload_index_o = result.payload_index;
  assign payload_byte_o  = result.payload_byte;
  assign payload_valid_o = result.payload_valid;
  assign last_o          = result.last;

endmodule
